/* hdl/best_fit_unit_allocator_macros.svh */
// Assertion macros used by the allocator checker.
`ifndef BEST_FIT_UNIT_ALLOCATOR_MACROS_SVH
`define BEST_FIT_UNIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BFUA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");

// Next-cycle implication, disabled during reset.
`define BFUA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");

`endif

/* hdl/bfua_pkg.sv */
// Shared types and constants of the best-fit unit allocator.
package bfua_pkg;

   localparam int unsigned UNITS_DEFAULT = 1024;

   localparam int unsigned CMD_W   = 1;
   localparam int unsigned SIZE_W  = 11;
   localparam int unsigned INDEX_W = 10;
   localparam int unsigned START_W = 10;
   localparam int unsigned FREE_W  = 11;
   localparam int unsigned STAT_W  = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 3'd0,
      ST_ZERO     = 3'd1,
      ST_EXCEEDS  = 3'd2,
      ST_NOFIT    = 3'd3,
      ST_NOTALLOC = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_SCAN_END,
      S_SCAN_CLOSE,
      S_MARK,
      S_FREE_RD,
      S_FREE_CHK,
      S_FREE_WR,
      S_DONE
   } state_type;

endpackage

/* hdl/bfua_req_if.sv */
// Request channel: command, allocate size and index to free.
interface bfua_req_if;
   import bfua_pkg::*;

   logic                 valid;
   logic                 ready;
   cmd_type              command;
   logic [SIZE_W-1:0]    alloc_size;
   logic [INDEX_W-1:0]   free_index;

   modport source (output valid, output command, output alloc_size, output free_index,
                   input ready);
   modport sink   (input valid, input command, input alloc_size, input free_index,
                   output ready);
endinterface

/* hdl/bfua_rsp_if.sv */
// Response channel: status, run start and free unit count.
interface bfua_rsp_if;
   import bfua_pkg::*;

   logic                 valid;
   logic                 ready;
   status_type           status;
   logic [START_W-1:0]   run_start;
   logic [FREE_W-1:0]    units_free;

   modport source (output valid, output status, output run_start, output units_free,
                   input ready);
   modport sink   (input valid, input status, input run_start, input units_free,
                   output ready);
endinterface

/* hdl/best_fit_unit_allocator.sv */
// Best-fit allocator over a pool of UNITS units, state held in one RAM.
//
// Requests arrive on req_if (valid/ready). An allocate names a size; the
// block scans the unit map for the smallest free run that fits, lowest start
// on ties, marks it used and records the length at its start. A free names a
// start index and releases the run recorded there. Every request yields one
// response on rsp_if with status, run start and the free count afterwards.
// Each RAM entry holds a used flag and the run length recorded at that unit.
// A rejected allocate is answered without a scan; an allocate scans the whole
// map at one RAM read per cycle, then marks size units (none on no fit); a
// free reads the entry at the index, then releases run length units, none
// when no run starts at the index. Marking and releasing sweep through the
// single RAM write port. One request is in work at a time.
// After reset a clearing pass writes every entry with req ready
// low. A finished response sits in the output register until taken; the next
// request is accepted and worked on meanwhile, and its result waits for the
// register to drain.
module best_fit_unit_allocator #(
   parameter int unsigned UNITS = bfua_pkg::UNITS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   bfua_req_if.sink   req_if,
   bfua_rsp_if.source rsp_if
);
   import bfua_pkg::*;

   localparam int unsigned IDX_W   = (UNITS > 1) ? $clog2(UNITS) : 1;
   localparam int unsigned CNT_W   = $clog2(UNITS + 1);
   localparam int unsigned ENTRY_W = CNT_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(UNITS - 1);

   state_type state_ff, state_in;

   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic               first_ff, first_in;
   logic               samp_valid_ff, samp_valid_in;
   logic [IDX_W-1:0]   samp_pos_ff, samp_pos_in;
   logic [CNT_W-1:0]   size_ff, size_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]   run_len_ff, run_len_in;
   logic [IDX_W-1:0]   run_begin_ff, run_begin_in;
   logic [CNT_W-1:0]   best_len_ff, best_len_in;
   logic [IDX_W-1:0]   best_start_ff, best_start_in;
   logic               found_ff, found_in;
   logic [CNT_W-1:0]   free_count_ff, free_count_in;
   status_type         res_status_ff, res_status_in;
   logic [START_W-1:0] res_start_ff, res_start_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [START_W-1:0] rsp_start_ff, rsp_start_in;
   logic [FREE_W-1:0]  rsp_free_ff, rsp_free_in;

   logic               req_accept;
   logic               out_free;
   logic               idx_out_of_pool;
   logic               size_too_big;
   logic               size_zero;
   logic               step_en;
   logic               step_used;
   logic [CNT_W:0]     free_sum;

   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic               rd_used;
   logic [CNT_W-1:0]   rd_len;

   bfua_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (UNITS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_used = ram_rd_data[CNT_W];
   assign rd_len  = ram_rd_data[CNT_W-1:0];

   assign req_accept      = req_if.valid && req_if.ready;
   assign out_free        = !rsp_valid_ff || rsp_if.ready;
   assign idx_out_of_pool = 32'(req_if.free_index) >= UNITS;
   assign size_too_big    = 32'(req_if.alloc_size) > 32'(free_count_ff);
   assign size_zero       = (req_if.alloc_size == '0);

   // Scan step: the pool end closes the last run like a used unit.
   assign step_en   = samp_valid_ff || (state_ff == S_SCAN_CLOSE);
   assign step_used = (state_ff == S_SCAN_CLOSE) ? 1'b1 : rd_used;

   always_comb begin
      run_len_in    = run_len_ff;
      run_begin_in  = run_begin_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      found_in      = found_ff;
      if (state_ff == S_IDLE) begin
         run_len_in = '0;
         found_in   = 1'b0;
      end else if (step_en) begin
         if (!step_used) begin
            if (run_len_ff == '0) begin
               run_begin_in = samp_pos_ff;
            end
            run_len_in = run_len_ff + CNT_W'(1);
         end else begin
            if (run_len_ff >= size_ff && (!found_ff || run_len_ff < best_len_ff)) begin
               found_in      = 1'b1;
               best_len_in   = run_len_ff;
               best_start_in = run_begin_ff;
            end
            run_len_in = '0;
         end
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (ptr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               if (req_if.command == CMD_FREE) begin
                  state_in = idx_out_of_pool ? S_DONE : S_FREE_RD;
               end else begin
                  state_in = (size_too_big || size_zero) ? S_DONE : S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (ptr_ff == LAST_IDX) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END:   state_in = S_SCAN_CLOSE;
         S_SCAN_CLOSE: state_in = found_in ? S_MARK : S_DONE;
         S_MARK: begin
            if (rem_ff == CNT_W'(1)) begin
               state_in = S_DONE;
            end
         end
         S_FREE_RD:  state_in = S_FREE_CHK;
         S_FREE_CHK: state_in = (rd_len == '0) ? S_DONE : S_FREE_WR;
         S_FREE_WR: begin
            if (rem_ff == CNT_W'(1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // Outputs: RAM control and request ready
   always_comb begin
      req_if.ready = (state_ff == S_IDLE);
      ram_wr_en    = 1'b0;
      ram_wr_addr  = ptr_ff;
      ram_wr_data  = '0;
      ram_rd_addr  = ptr_ff;
      case (state_ff)
         S_CLEAR:   ram_wr_en = 1'b1;
         S_MARK: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = {1'b1, (first_ff ? size_ff : CNT_W'(0))};
         end
         S_FREE_WR: ram_wr_en = 1'b1;
         S_FREE_RD: ram_rd_addr = IDX_W'(idx_ff);
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   assign free_sum = {1'b0, free_count_ff} + {1'b0, rd_len};

   // Datapath registers
   always_comb begin
      ptr_in        = ptr_ff;
      rem_in        = rem_ff;
      first_in      = first_ff;
      samp_valid_in = (state_ff == S_SCAN);
      samp_pos_in   = ptr_ff;
      size_in       = size_ff;
      idx_in        = idx_ff;
      free_count_in = free_count_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_free_in   = rsp_free_ff;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: ptr_in = ptr_ff + IDX_W'(1);
         S_IDLE: begin
            ptr_in  = '0;
            size_in = CNT_W'(req_if.alloc_size);
            idx_in  = req_if.free_index;
            if (req_accept) begin
               if (req_if.command == CMD_FREE) begin
                  res_status_in = ST_NOTALLOC;
                  res_start_in  = START_W'(req_if.free_index);
               end else begin
                  res_start_in = '0;
                  if (size_too_big) begin
                     res_status_in = ST_EXCEEDS;
                  end else if (size_zero) begin
                     res_status_in = ST_ZERO;
                  end else begin
                     res_status_in = ST_NOFIT;
                  end
               end
            end
         end
         S_SCAN: ptr_in = ptr_ff + IDX_W'(1);
         S_SCAN_CLOSE: begin
            ptr_in   = best_start_in;
            rem_in   = size_ff;
            first_in = 1'b1;
            if (found_in) begin
               res_status_in = ST_OK;
               res_start_in  = START_W'(best_start_in);
               free_count_in = free_count_ff - size_ff;
            end
         end
         S_MARK: begin
            ptr_in   = ptr_ff + IDX_W'(1);
            rem_in   = rem_ff - CNT_W'(1);
            first_in = 1'b0;
         end
         S_FREE_CHK: begin
            ptr_in = IDX_W'(idx_ff);
            rem_in = rd_len;
            if (rd_len != '0) begin
               res_status_in = ST_OK;
               free_count_in = (free_sum > (CNT_W+1)'(UNITS)) ?
                               CNT_W'(UNITS) : free_sum[CNT_W-1:0];
            end
         end
         S_FREE_WR: begin
            ptr_in = ptr_ff + IDX_W'(1);
            rem_in = rem_ff - CNT_W'(1);
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = res_start_ff;
               rsp_free_in   = FREE_W'(free_count_ff);
            end
         end
         default: begin
            ptr_in = ptr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         ptr_ff        <= '0;
         samp_valid_ff <= 1'b0;
         free_count_ff <= CNT_W'(UNITS);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         samp_valid_ff <= samp_valid_in;
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      first_ff      <= first_in;
      samp_pos_ff   <= samp_pos_in;
      size_ff       <= size_in;
      idx_ff        <= idx_in;
      run_len_ff    <= run_len_in;
      run_begin_ff  <= run_begin_in;
      best_len_ff   <= best_len_in;
      best_start_ff <= best_start_in;
      found_ff      <= found_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = rsp_status_ff;
   assign rsp_if.run_start  = rsp_start_ff;
   assign rsp_if.units_free = rsp_free_ff;
endmodule

/* hdl/bfua_ram.sv */
// Generic simple dual-port RAM, one write and one registered read per cycle.
module bfua_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* hdl/bfua_checker.sv */
// Port-level checks of the allocator, bound to the top level.
`include "best_fit_unit_allocator_macros.svh"

module bfua_checker #(
   parameter int unsigned UNITS = bfua_pkg::UNITS_DEFAULT
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input bfua_pkg::status_type         rsp_status,
   input logic [bfua_pkg::START_W-1:0] rsp_run_start,
   input logic [bfua_pkg::FREE_W-1:0]  rsp_units_free
);
   import bfua_pkg::*;

   // A response waiting for the receiver holds its value.
   `BFUA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_status) && $stable(rsp_run_start) && $stable(rsp_units_free))

   // One request in work: ready drops right after an accepted transaction.
   `BFUA_ASSERT_NEXT(a_one_in_work, clock, reset, req_valid && req_ready, !req_ready)

   // Rejected allocations report start zero.
   `BFUA_ASSERT_NOW(a_reject_start, clock, reset,
      rsp_valid && (rsp_status == ST_ZERO || rsp_status == ST_EXCEEDS || rsp_status == ST_NOFIT),
      rsp_run_start == '0)

   // Free count never exceeds the pool.
   `BFUA_ASSERT_NOW(a_free_bound, clock, reset, rsp_valid, 32'(rsp_units_free) <= UNITS)
endmodule

bind best_fit_unit_allocator bfua_checker #(.UNITS(UNITS)) u_bfua_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_status     (rsp_if.status),
   .rsp_run_start  (rsp_if.run_start),
   .rsp_units_free (rsp_if.units_free)
);
